/* src/fht_pkg.sv */
// ----------------------------------------------------------------------------
// fht_pkg
// Shared types, constants and helpers for the fragment hole tracker.
// ----------------------------------------------------------------------------
package fht_pkg;

  localparam int HOLE_ENTRIES = 8192;
  localparam int IDX_W        = $clog2(HOLE_ENTRIES);
  localparam int STEP_W       = IDX_W + 1;

  localparam logic [15:0] NO_HOLE      = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME    = 16'd34;
  localparam logic [16:0] ETH_HDR      = 17'd14;
  localparam logic [16:0] MIN_LAST     = 17'd7;

  typedef logic [IDX_W-1:0] slot_t;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] last;
    logic [15:0] next;
    logic [15:0] prev;
  } hole_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] frame_size;
    logic [5:0]  ip_header_bytes;
    logic [15:0] ip_total_length;
    logic [15:0] fragment_offset_bytes;
    logic        more_fragments;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] copy_first;
    logic [15:0] copy_last;
    logic        complete;
    logic [15:0] datagram_last_byte;
  } out_t;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_NOCHG     = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_SHORT     = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic        err;
    logic        trim;
    logic [15:0] dlast;
  } chk_t;

  // field write mask: [3] first, [2] last, [1] next, [0] prev
  localparam logic [3:0] MASK_NEXT = 4'b0010;
  localparam logic [3:0] MASK_PREV = 4'b0001;
  localparam logic [3:0] MASK_ALL  = 4'b1111;
  localparam logic [3:0] MASK_NONE = 4'b0000;

  typedef struct packed {
    logic       re;
    slot_t      raddr;
    logic [3:0] wmask;
    slot_t      waddr;
    hole_t      wdata;
  } ram_req_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_NEXT,
    OP_PREV,
    OP_FULL
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [15:0] at;
    hole_t       rec;
  } wr_op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_TRIM_RD,
    S_TRIM_EV,
    S_WALK_RD,
    S_WALK_EV,
    S_WR,
    S_DONE
  } state_e;

  function automatic slot_t slot_of(input logic [15:0] off);
    slot_of = off[IDX_W+2:3];
  endfunction

  function automatic wr_op_t op_none();
    wr_op_t o;
    o.kind = OP_NONE;
    o.at   = NO_HOLE;
    o.rec  = '0;
    return o;
  endfunction

  function automatic wr_op_t op_next(input logic [15:0] at, input logic [15:0] v);
    wr_op_t o;
    o.kind     = OP_NEXT;
    o.at       = at;
    o.rec      = '0;
    o.rec.next = v;
    return o;
  endfunction

  function automatic wr_op_t op_prev(input logic [15:0] at, input logic [15:0] v);
    wr_op_t o;
    o.kind     = OP_PREV;
    o.at       = at;
    o.rec      = '0;
    o.rec.prev = v;
    return o;
  endfunction

  function automatic wr_op_t op_full(input logic [15:0] at, input hole_t h);
    wr_op_t o;
    o.kind = OP_FULL;
    o.at   = at;
    o.rec  = h;
    return o;
  endfunction

endpackage

/* src/fht_size_check.sv */
// ----------------------------------------------------------------------------
// fht_size_check
// Size rules, fragment end computation and rounding for one descriptor.
// ----------------------------------------------------------------------------
module fht_size_check import fht_pkg::*; (
  input  in_t         item,
  input  logic [15:0] end_offset,
  output chk_t        chk
);

  logic        bad_size;
  logic [16:0] sum;
  logic [16:0] rnd;
  logic        trim;

  always_comb begin
    bad_size = (item.frame_size < MIN_FRAME) ||
               (item.ip_total_length <= {10'd0, item.ip_header_bytes}) ||
               (({1'b0, item.ip_total_length} + ETH_HDR) > {1'b0, item.frame_size});
    sum  = {1'b0, item.ip_total_length} - {11'd0, item.ip_header_bytes} - 17'd1
           + {1'b0, item.fragment_offset_bytes};
    trim = !item.more_fragments && (end_offset > sum[15:0]);
    // round end down so that end+1 is a multiple of 8
    rnd  = ((sum + 17'd1) & ~17'd7) - 17'd1;

    chk.err    = 1'b1;
    chk.trim   = trim;
    chk.dlast  = trim ? sum[15:0] : rnd[15:0];
    if (bad_size) begin
      chk.status = ST_MALFORMED;
    end else if (sum[16]) begin
      chk.status = ST_OVERFLOW;
    end else if (!trim && (sum < MIN_LAST)) begin
      chk.status = ST_SHORT;
    end else begin
      chk.status = ST_NOCHG;
      chk.err    = 1'b0;
    end
  end

endmodule

/* src/fht_hole_ram.sv */
// ----------------------------------------------------------------------------
// fht_hole_ram
// Hole table: one read port with registered data, one field-masked write port.
// ----------------------------------------------------------------------------
module fht_hole_ram import fht_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output hole_t    rdata
);

  logic [15:0] mem_first [HOLE_ENTRIES];
  logic [15:0] mem_last  [HOLE_ENTRIES];
  logic [15:0] mem_next  [HOLE_ENTRIES];
  logic [15:0] mem_prev  [HOLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wmask[3]) mem_first[req.waddr] <= req.wdata.first;
    if (req.wmask[2]) mem_last[req.waddr]  <= req.wdata.last;
    if (req.wmask[1]) mem_next[req.waddr]  <= req.wdata.next;
    if (req.wmask[0]) mem_prev[req.waddr]  <= req.wdata.prev;
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata.first <= mem_first[req.raddr];
      rdata.last  <= mem_last[req.raddr];
      rdata.next  <= mem_next[req.raddr];
      rdata.prev  <= mem_prev[req.raddr];
    end
  end

endmodule

/* src/fht_walker.sv */
// ----------------------------------------------------------------------------
// fht_walker
// Sequencer: trims and walks the hole list, queues link updates, builds result.
// ----------------------------------------------------------------------------
module fht_walker import fht_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_t      in_data,
  output logic     res_valid,
  input  logic     res_take,
  output out_t     res,
  output ram_req_t ram,
  input  hole_t    r
);

  state_e      state, state_next;
  state_e      ret, ret_next;
  logic [1:0]  wi, wi_next;
  wr_op_t      wq [3];
  wr_op_t      wq_next [3];
  logic [15:0] iter, iter_next;
  logic [STEP_W-1:0] steps, steps_next;
  logic [15:0] head, head_next;
  logic [15:0] tail, tail_next;
  logic [15:0] end_off, end_off_next;
  logic [15:0] dlast, dlast_next;
  status_e     status, status_next;
  logic        mod, mod_next;
  in_t         item, item_next;
  chk_t        chk;
  wr_op_t      op;
  logic        walk_end;
  logic [15:0] dfirst;
  logic [15:0] nstart;
  hole_t       h0;
  hole_t       h1;

  fht_size_check u_chk (
    .item       (item),
    .end_offset (end_off),
    .chk        (chk)
  );

  assign dfirst   = item.fragment_offset_bytes;
  assign nstart   = dlast + 16'd1;
  assign walk_end = (iter == NO_HOLE) || (steps == STEP_W'(HOLE_ENTRIES));
  assign op       = wq[wi];

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    wi_next      = wi;
    wq_next      = wq;
    iter_next    = iter;
    steps_next   = steps;
    head_next    = head;
    tail_next    = tail;
    end_off_next = end_off;
    dlast_next   = dlast;
    status_next  = status;
    mod_next     = mod;
    item_next    = item;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    ram          = '0;
    h0           = r;
    h1           = r;

    res.status             = mod ? ST_NEW : status;
    res.copy_first         = mod ? dfirst : 16'd0;
    res.copy_last          = mod ? dlast : 16'd0;
    res.complete           = (head == NO_HOLE);
    res.datagram_last_byte = end_off;

    case (state)
      S_INIT: begin
        ram.wmask = MASK_ALL;
        ram.waddr = '0;
        ram.wdata = '{first: 16'd0, last: 16'hFFFF, next: NO_HOLE, prev: NO_HOLE};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next  = in_data;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        mod_next   = 1'b0;
        steps_next = '0;
        iter_next  = head;
        dlast_next = chk.dlast;
        if (item.mode) begin
          h0 = '{first: 16'd0, last: 16'hFFFF, next: NO_HOLE, prev: NO_HOLE};
          wq_next[0]   = op_full(16'd0, h0);
          wq_next[1]   = op_none();
          wq_next[2]   = op_none();
          head_next    = 16'd0;
          tail_next    = 16'd0;
          end_off_next = 16'hFFFF;
          status_next  = ST_NOCHG;
          wi_next      = '0;
          ret_next     = S_DONE;
          state_next   = S_WR;
        end else if (chk.err) begin
          status_next = chk.status;
          state_next  = S_DONE;
        end else begin
          status_next = ST_NOCHG;
          if (chk.trim) begin
            end_off_next = chk.dlast;
            state_next   = S_TRIM_RD;
          end else begin
            state_next = S_WALK_RD;
          end
        end
      end
      S_TRIM_RD: begin
        if (walk_end) begin
          iter_next  = head;
          steps_next = '0;
          state_next = S_WALK_RD;
        end else begin
          ram.re     = 1'b1;
          ram.raddr  = slot_of(iter);
          state_next = S_TRIM_EV;
        end
      end
      S_TRIM_EV: begin
        steps_next = steps + STEP_W'(1);
        iter_next  = r.next;
        wi_next    = '0;
        ret_next   = S_TRIM_RD;
        wq_next[0] = op_none();
        wq_next[1] = op_none();
        wq_next[2] = op_none();
        if (r.first > end_off) begin
          wq_next[0] = op_next(r.prev, r.next);
          wq_next[1] = op_prev(r.next, r.prev);
          state_next = S_WR;
        end else if (r.last > end_off) begin
          h0.last    = end_off;
          wq_next[0] = op_full(iter, h0);
          state_next = S_WR;
        end else begin
          state_next = S_TRIM_RD;
        end
      end
      S_WALK_RD: begin
        if (walk_end) begin
          state_next = S_DONE;
        end else begin
          ram.re     = 1'b1;
          ram.raddr  = slot_of(iter);
          state_next = S_WALK_EV;
        end
      end
      S_WALK_EV: begin
        steps_next = steps + STEP_W'(1);
        wi_next    = '0;
        wq_next[0] = op_none();
        wq_next[1] = op_none();
        wq_next[2] = op_none();
        ret_next   = S_DONE;
        state_next = S_DONE;
        if (dlast == r.last) begin
          // fragment ends where the hole ends
          mod_next   = 1'b1;
          state_next = S_WR;
          if (dfirst <= r.first) begin
            wq_next[0] = op_next(r.prev, r.next);
            wq_next[1] = op_prev(r.next, r.prev);
          end else begin
            h0.last    = dfirst - 16'd1;
            wq_next[0] = op_full(iter, h0);
          end
        end else if (dlast < r.last) begin
          if (dfirst <= r.first) begin
            // hole moves its start past the fragment
            if (({1'b0, dlast} + 17'd1) > {1'b0, r.first}) begin
              h0.first   = nstart;
              wq_next[0] = op_next(r.prev, nstart);
              wq_next[1] = op_prev(r.next, nstart);
              wq_next[2] = op_full(nstart, h0);
              mod_next   = 1'b1;
              state_next = S_WR;
            end
          end else begin
            // split into a front and a back hole
            h0.last    = dfirst - 16'd1;
            h0.next    = nstart;
            h1.first   = nstart;
            h1.prev    = iter;
            wq_next[0] = op_prev(r.next, nstart);
            wq_next[1] = op_full(iter, h0);
            wq_next[2] = op_full(nstart, h1);
            mod_next   = 1'b1;
            state_next = S_WR;
          end
        end else begin
          iter_next  = r.next;
          ret_next   = S_WALK_RD;
          state_next = S_WALK_RD;
          if (dfirst <= r.first) begin
            wq_next[0] = op_next(r.prev, r.next);
            wq_next[1] = op_prev(r.next, r.prev);
            mod_next   = 1'b1;
            state_next = S_WR;
          end else if (r.last >= dfirst) begin
            h0.last    = dfirst - 16'd1;
            wq_next[0] = op_full(iter, h0);
            mod_next   = 1'b1;
            state_next = S_WR;
          end
        end
      end
      S_WR: begin
        case (op.kind)
          OP_NEXT: begin
            if (op.at == NO_HOLE) begin
              head_next = op.rec.next;
            end else begin
              ram.wmask = MASK_NEXT;
            end
          end
          OP_PREV: begin
            if (op.at == NO_HOLE) begin
              tail_next = op.rec.prev;
            end else begin
              ram.wmask = MASK_PREV;
            end
          end
          OP_FULL: ram.wmask = MASK_ALL;
          default: ram.wmask = MASK_NONE;
        endcase
        ram.waddr = slot_of(op.at);
        ram.wdata = op.rec;
        if (wi == 2'd2) begin
          wi_next    = '0;
          state_next = ret;
        end else begin
          wi_next = wi + 2'd1;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      wi      <= '0;
      head    <= 16'd0;
      tail    <= 16'd0;
      end_off <= 16'hFFFF;
      mod     <= 1'b0;
    end else begin
      state   <= state_next;
      wi      <= wi_next;
      head    <= head_next;
      tail    <= tail_next;
      end_off <= end_off_next;
      mod     <= mod_next;
    end
  end

  always_ff @(posedge clk) begin
    ret    <= ret_next;
    wq     <= wq_next;
    iter   <= iter_next;
    steps  <= steps_next;
    dlast  <= dlast_next;
    status <= status_next;
    item   <= item_next;
  end

endmodule

/* src/ip_fragment_hole_tracker_unit.sv */
// ----------------------------------------------------------------------------
// ip_fragment_hole_tracker_unit
// RFC 815 hole list of one IPv4 datagram kept in an on-chip hole table.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A descriptor that fails the
// size checks passes through the idle, check and result states; a restart
// writes the record for hole 0..65535 through three write slots. An accepted
// fragment passes through a read state and an evaluate state for each hole
// visited in the list walk (one read of the hole table and its evaluation),
// plus the three write slots for each hole that is deleted, shrunk or split
// (link and record writes go through the one write port in turn), plus a
// last read state when the walk runs off the end of the list. A last fragment
// that lowers the datagram end first runs a trim walk over the whole list
// with the same steps per hole, plus a last trim read state to leave it.
// The result sits in an output register, so the next transaction is taken
// as soon as the walker returns to idle even if the result waits; only a
// second result that finds the register still full holds the walker until
// the first one is taken. After reset the block writes the initial hole
// 0..65535 into table entry 0 before it takes a transaction.
// ----------------------------------------------------------------------------
module ip_fragment_hole_tracker_unit import fht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ram_req_t ram;
  hole_t    rdata;
  logic     res_valid;
  logic     res_take;
  out_t     res;

  // output slot is free when empty or being drained this cycle
  assign res_take = !out_valid || out_ready;

  fht_hole_ram u_ram (
    .clk   (clk),
    .req   (ram),
    .rdata (rdata)
  );

  fht_walker u_walk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram       (ram),
    .r         (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) out_data <= res;
  end

endmodule
